[src/sha256_byte_stream_hasher_defines.svh]
// Assertion macros for the SHA-256 byte-stream hasher.
// Needs no other file; included by the top level.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
// implication checked at every rising clock edge outside reset
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[src/sha_pkg.sv]
// Package for the SHA-256 byte-stream hasher: beat types, constants, round functions.
// Depends on nothing.
package sha_pkg;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        is_last_word;
	} sha_out_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sm_s0(input logic [31:0] x);
		sm_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sm_s1(input logic [31:0] x);
		sm_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction
endpackage

[src/sha256_byte_stream_hasher.sv]
// Top level of the SHA-256 byte-stream hasher: byte collection, padding, round engine.
// Depends on sha_pkg and sha256_byte_stream_hasher_defines.svh.
//
// channel  dir  handshake             payload
// in_*     in   in_valid / in_stall   sha_in_t  (data_byte, has_byte, is_last)
// out_*    out  out_valid / out_stall sha_out_t (digest_word, word_index, is_last_word)
//
// A plain byte is taken while idle; the 64th byte of a block starts a compression
// (load, 64 rounds through the shared round unit, chain add).
// An ending beat writes the padding one byte a cycle up to byte 63, runs one compression,
// or two when the 0x80 mark lands at byte 56 or later, then streams eight digest words,
// each read from the chain registers and held under out_stall.
// in_stall is high whenever the sequencer is not idle. Reset is asynchronous.
`include "sha256_byte_stream_hasher_defines.svh"
module sha256_byte_stream_hasher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sha_pkg::sha_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output sha_pkg::sha_out_t out_data
);
	import sha_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT
	} state_t;

	state_t      state_q;
	logic        ending_q;   // compression belongs to the padding sequence
	logic        mark_q;     // 0x80 mark still to be written
	logic        len_blk_q;  // current pad block carries the length field
	logic [60:0] count_q;
	logic [63:0] bits_q;
	logic [5:0]  pos_q;
	logic [5:0]  round_q;
	logic [2:0]  widx_q;
	logic [31:0] chain_q [8];
	logic [31:0] work_q [8];
	logic [31:0] sched_q [16]; // block words, then the rolling schedule

	logic        in_fire;
	logic [60:0] cnt_next;
	logic [7:0]  pad_byte;
	logic [31:0] w_cur, t1, t2;
	logic [3:0]  ri;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign ri       = round_q[3:0];
	assign cnt_next = count_q + {60'd0, in_data.has_byte};

	// shared round unit
	always_comb begin
		if (round_q < 6'd16)
			w_cur = sched_q[ri];
		else
			w_cur = sm_s1(sched_q[ri - 4'd2]) + sched_q[ri - 4'd7]
				+ sm_s0(sched_q[ri - 4'd15]) + sched_q[ri];
		t1 = work_q[7] + big_s1(work_q[4])
			+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
			+ ROUND_K[round_q] + w_cur;
		t2 = big_s0(work_q[0])
			+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
	end

	// padding byte for the current position
	always_comb begin
		if (mark_q)
			pad_byte = PAD_BYTE;
		else if (len_blk_q && pos_q >= LEN_POS)
			pad_byte = bits_q[{~pos_q[2:0], 3'b111} -: 8];
		else
			pad_byte = 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ending_q  <= 1'b0;
			mark_q    <= 1'b0;
			len_blk_q <= 1'b0;
			count_q   <= '0;
			bits_q    <= '0;
			pos_q     <= '0;
			round_q   <= '0;
			widx_q    <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < 8; i++) chain_q[i] <= INIT_H[i];
			for (int i = 0; i < 8; i++) work_q[i] <= '0;
			for (int i = 0; i < 16; i++) sched_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_data.has_byte) begin
							sched_q[count_q[5:2]][{~count_q[1:0], 3'b111} -: 8] <=
								in_data.data_byte;
							count_q <= cnt_next;
						end
						if (in_data.is_last)
							bits_q <= {cnt_next, 3'b000};
						if (in_data.has_byte && count_q[5:0] == 6'd63) begin
							state_q   <= ST_LOAD;
							ending_q  <= in_data.is_last;
							mark_q    <= in_data.is_last;
							len_blk_q <= 1'b0;
						end else if (in_data.is_last) begin
							state_q   <= ST_PAD;
							ending_q  <= 1'b1;
							mark_q    <= 1'b1;
							pos_q     <= cnt_next[5:0];
							len_blk_q <= (cnt_next[5:0] < LEN_POS);
						end
					end
				end
				ST_PAD: begin
					sched_q[pos_q[5:2]][{~pos_q[1:0], 3'b111} -: 8] <= pad_byte;
					mark_q <= 1'b0;
					pos_q  <= pos_q + 6'd1;
					if (pos_q == 6'd63) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					for (int i = 0; i < 8; i++) work_q[i] <= chain_q[i];
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (round_q >= 6'd16) sched_q[ri] <= w_cur;
					for (int i = 1; i < 8; i++)
						if (i != 4) work_q[i] <= work_q[i-1];
					work_q[4] <= work_q[3] + t1;
					work_q[0] <= t1 + t2;
					round_q   <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + work_q[i];
					if (!ending_q)
						state_q <= ST_IDLE;
					else if (!len_blk_q) begin
						// follow with the block that carries the length
						state_q   <= ST_PAD;
						pos_q     <= 6'd0;
						len_blk_q <= 1'b1;
					end else begin
						state_q   <= ST_EMIT;
						widx_q    <= '0;
						out_valid <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (!out_stall) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == 3'd7) begin
							out_valid <= 1'b0;
							state_q   <= ST_IDLE;
							ending_q  <= 1'b0;
							mark_q    <= 1'b0;
							len_blk_q <= 1'b0;
							count_q   <= '0;
							for (int i = 0; i < 8; i++) chain_q[i] <= INIT_H[i];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_data.digest_word  = chain_q[widx_q];
	assign out_data.word_index   = widx_q;
	assign out_data.is_last_word = (widx_q == 3'd7);

	`SHA_ASSERT_IMPL(a_out_only_emit, clk, arst_n, out_valid, state_q == ST_EMIT,
		"digest beat outside emit")
	`SHA_ASSERT_IMPL(a_busy_stalls, clk, arst_n, state_q == ST_ROUND, in_stall,
		"input taken during rounds")
	`SHA_ASSERT_NEXT(a_round_adv, clk, arst_n, state_q == ST_ROUND && round_q != 6'd63,
		round_q == $past(round_q) + 6'd1, "round counter skipped")
endmodule

[sim/tb_sha256_byte_stream_hasher.sv]
// Testbench for the SHA-256 byte-stream hasher: random byte messages in, digest words checked.
// Depends on sha_pkg and the sha256_byte_stream_hasher top level.
module tb_sha256_byte_stream_hasher;
	import sha_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     in_valid = 1'b0;
	logic     in_stall;
	sha_in_t  in_data = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	sha_out_t out_data;

	sha256_byte_stream_hasher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	sha_in_t  pending_beats[$];
	sha_out_t digest_expect[$];
	int       fail_count = 0;
	bit       hold_sender = 1'b0;
	int       hold_receiver = 0;

	// predictor state
	logic [31:0] chain_h[8];
	logic [7:0]  msg_block[64];
	logic [60:0] byte_count;

	localparam logic [31:0] IV[8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [31:0] KTAB[64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_msg_block();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		for (int i = 0; i < 8; i++)
			v[i] = chain_h[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_h[i] += v[i];
	endtask

	task automatic restart_digest();
		for (int i = 0; i < 8; i++)
			chain_h[i] = IV[i];
		byte_count = '0;
	endtask

	task automatic hash_beat(sha_in_t b);
		int pos;
		logic [63:0] bit_len;
		sha_out_t o;
		if (b.has_byte) begin
			pos = byte_count[5:0];
			msg_block[pos] = b.data_byte;
			byte_count++;
			if (pos == 63)
				compress_msg_block();
		end
		if (!b.is_last)
			return;
		bit_len = {byte_count, 3'b000};
		pos = byte_count[5:0];
		msg_block[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			compress_msg_block();
			pos = 0;
		end
		while (pos < 56) begin
			msg_block[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			msg_block[56+i] = bit_len[63-8*i -: 8];
		compress_msg_block();
		for (int i = 0; i < 8; i++) begin
			o.digest_word = chain_h[i];
			o.word_index = 3'(i);
			o.is_last_word = (i == 7);
			digest_expect.push_back(o);
		end
		restart_digest();
	endtask

	function automatic int gap_len();
		return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
	endfunction

	task automatic queue_message(int len, bit end_with_byte);
		sha_in_t b;
		for (int i = 0; i < len; i++) begin
			b.data_byte = 8'($urandom);
			b.has_byte = 1'b1;
			b.is_last = end_with_byte && (i == len - 1);
			pending_beats.push_back(b);
		end
		if (!end_with_byte || len == 0) begin
			b.data_byte = 8'($urandom);
			b.has_byte = 1'b0;
			b.is_last = 1'b1;
			pending_beats.push_back(b);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// acceptance seen at the rising edge, acted on at the following falling edge
	logic in_stall_q;
	always @(posedge clk)
		in_stall_q <= !(in_valid && !in_stall) ? 1'b1 : 1'b0;

	// driver
	int send_gap = 0;
	always @(negedge clk) begin
		if (in_valid && !in_stall_q) begin
			hash_beat(in_data);
			pending_beats.pop_front();
		end
		if (!arst_n || hold_sender) begin
			in_valid <= 1'b0;
		end else if (in_valid && in_stall_q) begin
			in_valid <= 1'b1;
		end else if (send_gap > 0) begin
			send_gap--;
			in_valid <= 1'b0;
		end else if (pending_beats.size() > 0) begin
			in_valid <= 1'b1;
			in_data <= pending_beats[0];
			send_gap = ($urandom_range(2) == 0) ? gap_len() : 0;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		sha_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (digest_expect.size() == 0) begin
				$error("unexpected digest beat %h", out_data);
				fail_count++;
			end else begin
				e = digest_expect.pop_front();
				if (out_data.digest_word !== e.digest_word) begin
					$error("digest_word expected %h actual %h", e.digest_word,
						out_data.digest_word);
					fail_count++;
				end
				if (out_data.word_index !== e.word_index) begin
					$error("word_index expected %0d actual %0d", e.word_index,
						out_data.word_index);
					fail_count++;
				end
				if (out_data.is_last_word !== e.is_last_word) begin
					$error("is_last_word expected %0d actual %0d", e.is_last_word,
						out_data.is_last_word);
					fail_count++;
				end
			end
		end
	end

	// receiver stall
	int stall_left = 0;
	always @(negedge clk) begin
		if (hold_receiver > 0) begin
			hold_receiver--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(3) == 0) begin
			stall_left = gap_len();
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		#40_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		sha_in_t b;
		arst_n = 1'b0;
		restart_digest();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty message, idle beats, extremes
		queue_message(0, 0);
		b = '{data_byte: 8'hff, has_byte: 1'b0, is_last: 1'b0};
		pending_beats.push_back(b);
		b = '{data_byte: 8'h00, has_byte: 1'b1, is_last: 1'b1};
		pending_beats.push_back(b);
		b = '{data_byte: 8'hff, has_byte: 1'b1, is_last: 1'b0};
		pending_beats.push_back(b);
		b = '{data_byte: 8'h00, has_byte: 1'b0, is_last: 1'b0};
		pending_beats.push_back(b);
		b = '{data_byte: 8'haa, has_byte: 1'b1, is_last: 1'b1};
		pending_beats.push_back(b);
		queue_message(3, 0);
		wait (pending_beats.size() == 0);
		// two compressions in padding, last byte closing a block, block crossed mid-message
		queue_message(56, 1);
		queue_message(64, 1);
		queue_message(65, 1);
		// receiver holds off long while sender keeps offering beats
		hold_receiver = 400;
		wait (pending_beats.size() == 0);
		// sender pause until every digest word is drained
		hold_sender = 1;
		wait (digest_expect.size() == 0);
		repeat (200) @(posedge clk);
		hold_sender = 0;
		// random messages, short, with idle noise
		for (int m = 0; m < 4; m++) begin
			if ($urandom_range(3) == 0) begin
				b.data_byte = 8'($urandom);
				b.has_byte = 1'b0;
				b.is_last = 1'b0;
				pending_beats.push_back(b);
			end
			queue_message($urandom_range(8), $urandom_range(1));
		end
		wait (pending_beats.size() == 0);
		wait (digest_expect.size() == 0);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[filelist.f]
+incdir+src
src/sha_pkg.sv
src/sha256_byte_stream_hasher.sv
sim/tb_sha256_byte_stream_hasher.sv
